>>> hw/rtl/ghash_pkg.sv
// Shared types, constants and the GF(2^128) digit step for the GHASH engine.
// Used by ghash_front, ghash_queue, ghash_back and gcm_ghash_engine_core.
package ghash_pkg;

  localparam int BLOCK_W     = 128;
  localparam int HALF_W      = 64;
  localparam int COUNT_W     = 5;
  localparam int BLOCK_BYTES = 16;
  localparam int TOTAL_W     = 61;
  localparam int DIGIT_W     = 8;
  localparam int DIGITS      = BLOCK_W / DIGIT_W;
  localparam int QUEUE_DEPTH = 2;
  localparam int TDATA_IN_W  = 136;
  localparam int TUSER_IN_W  = 2;
  localparam logic [7:0] REDUCE = 8'he1;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_AAD    = 2'd1,
    CMD_TEXT   = 2'd2,
    CMD_FINISH = 2'd3
  } cmd_t;

  typedef enum logic {
    CFG_KEY_HIGH = 1'b0,
    CFG_KEY_LOW  = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    cmd_t                 cmd;
    logic [BLOCK_W-1:0]   block;
    logic [COUNT_W-1:0]   count;
  } item_t;

  typedef struct packed {
    logic [BLOCK_W-1:0] z;
    logic [BLOCK_W-1:0] v;
  } mul_t;

  // Eight multiply steps, top bit of the digit first (GCM bit order).
  function automatic mul_t mul_digit(mul_t s, logic [DIGIT_W-1:0] d);
    mul_t r;
    logic carry;
    r = s;
    for (int i = DIGIT_W - 1; i >= 0; i--) begin
      if (d[i]) begin
        r.z = r.z ^ r.v;
      end
      carry = r.v[0];
      r.v = {1'b0, r.v[BLOCK_W-1:1]};
      if (carry) begin
        r.v[BLOCK_W-1 -: 8] = r.v[BLOCK_W-1 -: 8] ^ REDUCE;
      end
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/ghash_front.sv
// Front end: accepts stream items, clamps the byte count, pads the block
// and drops empty absorbs. Depends on ghash_pkg.
module ghash_front (
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [ghash_pkg::TDATA_IN_W-1:0] s_tdata,  // block_high, block_low, byte_count
  input  logic [ghash_pkg::TUSER_IN_W-1:0] s_tuser,  // command
  output logic                          push_valid,
  input  logic                          push_ready,
  output ghash_pkg::item_t              push_item
);

  ghash_pkg::cmd_t                    cmd;
  logic [ghash_pkg::COUNT_W-1:0]      raw_count;
  logic [ghash_pkg::COUNT_W-1:0]      count;
  logic [ghash_pkg::BLOCK_W-1:0]      block;
  logic [ghash_pkg::BLOCK_W-1:0]      mask;
  logic                               is_absorb;

  assign cmd       = ghash_pkg::cmd_t'(s_tuser);
  assign raw_count = s_tdata[2*ghash_pkg::HALF_W +: ghash_pkg::COUNT_W];
  assign count     = (raw_count > ghash_pkg::COUNT_W'(ghash_pkg::BLOCK_BYTES)) ?
                     ghash_pkg::COUNT_W'(ghash_pkg::BLOCK_BYTES) : raw_count;
  assign block     = {s_tdata[ghash_pkg::HALF_W-1:0],
                      s_tdata[ghash_pkg::HALF_W +: ghash_pkg::HALF_W]};
  assign is_absorb = (cmd == ghash_pkg::CMD_AAD) || (cmd == ghash_pkg::CMD_TEXT);

  always_comb begin
    for (int i = 0; i < ghash_pkg::BLOCK_BYTES; i++) begin
      mask[ghash_pkg::BLOCK_W-1-8*i -: 8] = {8{count > ghash_pkg::COUNT_W'(i)}};
    end
  end

  assign s_tready        = push_ready;
  assign push_valid      = s_tvalid && !(is_absorb && (count == '0));
  assign push_item.cmd   = cmd;
  assign push_item.block = block & mask;
  assign push_item.count = count;

endmodule

>>> hw/rtl/ghash_queue.sv
// Short FIFO of classified items between front and back end.
// Depends on ghash_pkg.
module ghash_queue #(
  parameter int DEPTH = ghash_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  ghash_pkg::item_t push_item,
  output logic             pop_valid,
  input  logic             pop_ready,
  output ghash_pkg::item_t pop_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ghash_pkg::item_t   mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   fill;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (fill != CNT_W'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_item   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/ghash_back.sv
// Back end: accumulator, byte totals and the digit-serial GF(2^128)
// multiplier (8 bits per cycle), plus the digest output register. Depends on ghash_pkg.
module ghash_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [ghash_pkg::BLOCK_W-1:0] hash_key,
  input  logic                          pop_valid,
  output logic                          pop_ready,
  input  ghash_pkg::item_t              pop_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ghash_pkg::BLOCK_W-1:0] out_digest
);

  localparam int CNT_W = $clog2(ghash_pkg::DIGITS);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_MUL  = 2'b10
  } state_t;

  state_t                          state;
  logic [ghash_pkg::BLOCK_W-1:0]   acc;
  logic [ghash_pkg::TOTAL_W-1:0]   aad_total;
  logic [ghash_pkg::TOTAL_W-1:0]   text_total;
  logic [ghash_pkg::BLOCK_W-1:0]   x;
  ghash_pkg::mul_t                 m;
  ghash_pkg::mul_t                 m_next;
  logic [CNT_W-1:0]                digit;
  logic                            fin;
  logic                            last;
  logic                            digest_load;

  assign pop_ready   = (state == ST_IDLE);
  assign m_next      = ghash_pkg::mul_digit(m, x[ghash_pkg::BLOCK_W-1 -: ghash_pkg::DIGIT_W]);
  assign last        = (digit == CNT_W'(ghash_pkg::DIGITS - 1));
  assign digest_load = (state == ST_MUL) && last && fin && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      acc        <= '0;
      aad_total  <= '0;
      text_total <= '0;
      out_valid  <= 1'b0;
      digit      <= '0;
      fin        <= 1'b0;
    end else begin
      if (digest_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (pop_valid) begin
            case (pop_item.cmd)
              ghash_pkg::CMD_CLEAR: begin
                acc        <= '0;
                aad_total  <= '0;
                text_total <= '0;
              end
              ghash_pkg::CMD_AAD: begin
                x         <= acc ^ pop_item.block;
                aad_total <= aad_total + ghash_pkg::TOTAL_W'(pop_item.count);
                m         <= '{z: '0, v: hash_key};
                digit     <= '0;
                fin       <= 1'b0;
                state     <= ST_MUL;
              end
              ghash_pkg::CMD_TEXT: begin
                x          <= acc ^ pop_item.block;
                text_total <= text_total + ghash_pkg::TOTAL_W'(pop_item.count);
                m          <= '{z: '0, v: hash_key};
                digit      <= '0;
                fin        <= 1'b0;
                state      <= ST_MUL;
              end
              ghash_pkg::CMD_FINISH: begin
                x          <= acc ^ {aad_total, 3'b000, text_total, 3'b000};
                aad_total  <= '0;
                text_total <= '0;
                m          <= '{z: '0, v: hash_key};
                digit      <= '0;
                fin        <= 1'b1;
                state      <= ST_MUL;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_MUL: begin
          if (!last) begin
            m     <= m_next;
            x     <= {x[ghash_pkg::BLOCK_W-ghash_pkg::DIGIT_W-1:0],
                      {ghash_pkg::DIGIT_W{1'b0}}};
            digit <= digit + 1'b1;
          end else if (!fin) begin
            acc   <= m_next.z;
            state <= ST_IDLE;
          end else if (!out_valid || out_ready) begin
            // digest leaves; accumulator restarts for the next message
            out_digest <= m_next.z;
            acc        <= '0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/gcm_ghash_engine_core.sv
// GHASH engine top level: key registers, config port, front, queue and back.
// Absorb/finish in the back end: a dequeue in the idle state, then the 16 multiply digits.
// The back end takes a new block only after the multiply of the last, paced by the 8-bit-per-cycle multiplier.
// Digest valid once the finish has passed the queue, the dequeue and all 16 multiply digits.
// Synchronous active-high reset clears key, accumulator, totals and the queue.
// Depends on ghash_pkg, ghash_front, ghash_queue, ghash_back.
module gcm_ghash_engine_core #(
  parameter int QUEUE_DEPTH = ghash_pkg::QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_index,
  input  logic [ghash_pkg::HALF_W-1:0]     cfg_data,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [ghash_pkg::TDATA_IN_W-1:0] s_tdata,  // block_high, block_low, byte_count
  input  logic [ghash_pkg::TUSER_IN_W-1:0] s_tuser,  // command
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [ghash_pkg::BLOCK_W-1:0]    m_tdata   // digest_high, digest_low
);

  logic [ghash_pkg::HALF_W-1:0]  key_high;
  logic [ghash_pkg::HALF_W-1:0]  key_low;
  logic                          push_valid;
  logic                          push_ready;
  ghash_pkg::item_t              push_item;
  logic                          pop_valid;
  logic                          pop_ready;
  ghash_pkg::item_t              pop_item;
  logic [ghash_pkg::BLOCK_W-1:0] digest;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (cfg_valid) begin
      case (ghash_pkg::cfg_reg_t'(cfg_index))
        ghash_pkg::CFG_KEY_HIGH: key_high <= cfg_data;
        ghash_pkg::CFG_KEY_LOW:  key_low  <= cfg_data;
        default:                 key_low  <= key_low;
      endcase
    end
  end

  ghash_front u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  ghash_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  ghash_back u_back (
    .clk        (clk),
    .rst        (rst),
    .hash_key   ({key_high, key_low}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_digest (digest)
  );

  assign m_tdata = {digest[ghash_pkg::HALF_W-1:0],
                    digest[ghash_pkg::HALF_W +: ghash_pkg::HALF_W]};

endmodule
